// ===== design/svi_pkg.sv =====
// ----------------------------------------------------------------------------
// svi_pkg
// Shared types and constants of the smoothstep vector interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package svi_pkg;

  localparam int DIMS_DEF = 3;
  localparam logic [15:0] DUR_RESET = 16'd500;

  // quotient bits of time / duration, one per divider step
  localparam int DIV_STEPS = 16;
  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_RETARGET = 2'd1,
    CMD_JUMP     = 2'd2
  } cmd_t;

  typedef struct packed {
    logic       take;
    logic       div_step;
    logic       sqr;
    logic       ease;
    logic       prod;
    logic       emit;
    logic       emit_comp;
    logic [2:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_ease;
    logic out_valid;
    logic out_taken;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/svi_in_if.sv =====
// ----------------------------------------------------------------------------
// svi_in_if
// Input channel: command items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface svi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [15:0]        elapsed_ms;
  logic [2:0]         elem_index;
  logic signed [31:0] target_value;
  logic               last_elem;

  modport source (
    output valid, cmd, elapsed_ms, elem_index, target_value, last_elem,
    input  ready
  );

  modport sink (
    input  valid, cmd, elapsed_ms, elem_index, target_value, last_elem,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/svi_out_if.sv =====
// ----------------------------------------------------------------------------
// svi_out_if
// Result channel: position elements with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface svi_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_index;
  logic signed [31:0] position;
  logic               finished;
  logic               last_out;

  modport source (
    output valid, out_index, position, finished, last_out,
    input  ready
  );

  modport sink (
    input  valid, out_index, position, finished, last_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/svi_dp.sv =====
// ----------------------------------------------------------------------------
// svi_dp
// Datapath: coordinate stores, restoring divider, easing multipliers and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module svi_dp #(
  parameter int DIMS = svi_pkg::DIMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  svi_pkg::ctrl_cmd_t  cmd,
  output svi_pkg::dp_sts_t    sts,
  input  logic [1:0]          in_cmd,
  input  logic [15:0]         in_elapsed_ms,
  input  logic [2:0]          in_elem_index,
  input  logic signed [31:0]  in_target_value,
  input  logic                in_last_elem,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_index,
  output logic signed [31:0]  position,
  output logic                finished,
  output logic                last_out
);
  import svi_pkg::*;

  localparam int IDX_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIMS - 1);

  logic signed [31:0] cur_r    [DIMS];
  logic signed [31:0] cur_nxt  [DIMS];
  logic signed [31:0] start_r  [DIMS];
  logic signed [31:0] start_nxt[DIMS];
  logic signed [31:0] goal_r   [DIMS];
  logic signed [31:0] goal_nxt [DIMS];
  logic signed [31:0] staged_r [DIMS];
  logic signed [31:0] staged_nxt[DIMS];

  logic [16:0] acc_r, acc_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] t2_r, t2_nxt;
  logic [16:0] s_r, s_nxt;
  logic signed [50:0] prod_r, prod_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_idx_r, out_idx_nxt;
  logic signed [31:0] out_pos_r, out_pos_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic               out_last_r, out_last_nxt;

  logic              is_load, take_tick;
  logic              moving, goal_differs, snap;
  logic [16:0]       acc_sum;
  logic [16:0]       rem_sh;
  logic [31:0]       sq;
  logic [17:0]       k;
  logic [33:0]       e;
  logic signed [32:0] diff;
  logic signed [31:0] pos;
  logic [IDX_W-1:0]  el;

  assign is_load   = cmd.take && (in_cmd == CMD_RETARGET || in_cmd == CMD_JUMP);
  assign take_tick = cmd.take && (in_cmd == CMD_TICK);
  assign acc_sum   = acc_r + {1'b0, in_elapsed_ms};
  assign snap      = (acc_sum >= {1'b0, dur_r});
  assign el        = cmd.idx[IDX_W-1:0];

  // staged write of the incoming element, seen by the commit compare
  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      staged_nxt[i] = staged_r[i];
    end
    if (is_load && ({1'b0, in_elem_index} < 4'(DIMS))) begin
      staged_nxt[in_elem_index[IDX_W-1:0]] = in_target_value;
    end
  end

  always_comb begin
    moving       = 1'b0;
    goal_differs = 1'b0;
    for (int i = 0; i < DIMS; i++) begin
      if (start_r[i] != goal_r[i]) begin
        moving = 1'b1;
      end
      if (staged_nxt[i] != goal_r[i]) begin
        goal_differs = 1'b1;
      end
    end
  end

  always_comb begin
    rem_sh = {rem_r, 1'b0};
    sq     = quo_r * quo_r;
    k      = 18'd196608 - {1'b0, quo_r, 1'b0};
    e      = 34'(t2_r) * 34'(k);
    diff   = {goal_r[el][31], goal_r[el]} - {start_r[el][31], start_r[el]};
    pos    = cmd.emit_comp ? (start_r[el] + prod_r[47:16]) : cur_r[el];
  end

  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      cur_nxt[i]   = cur_r[i];
      start_nxt[i] = start_r[i];
      goal_nxt[i]  = goal_r[i];
    end
    acc_nxt       = acc_r;
    dur_nxt       = cfg_we ? cfg_wdata : dur_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    t2_nxt        = t2_r;
    s_nxt         = s_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_pos_nxt   = out_pos_r;
    out_fin_nxt   = out_fin_r;
    out_last_nxt  = out_last_r;

    if (is_load && in_last_elem) begin
      if (in_cmd == CMD_JUMP) begin
        for (int i = 0; i < DIMS; i++) begin
          cur_nxt[i]   = staged_nxt[i];
          start_nxt[i] = staged_nxt[i];
          goal_nxt[i]  = staged_nxt[i];
        end
        acc_nxt = '0;
      end else if (goal_differs) begin
        for (int i = 0; i < DIMS; i++) begin
          start_nxt[i] = cur_r[i];
          goal_nxt[i]  = staged_nxt[i];
        end
        acc_nxt = '0;
      end
    end

    if (take_tick && moving) begin
      if (snap) begin
        acc_nxt = '0;
        for (int i = 0; i < DIMS; i++) begin
          cur_nxt[i]   = goal_r[i];
          start_nxt[i] = goal_r[i];
        end
      end else begin
        acc_nxt = acc_sum;
      end
      // acc_sum is below the duration whenever the divider runs (no snap), so it fits the remainder
      rem_nxt = acc_sum[15:0];
      quo_nxt = '0;
    end

    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dur_r}) begin
        rem_nxt = 16'(rem_sh - {1'b0, dur_r});
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[15:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
    end

    if (cmd.sqr) begin
      t2_nxt = sq[31:16];
    end

    if (cmd.ease) begin
      s_nxt = (e[33:16] > 18'd65536) ? 17'd65536 : e[32:16];
    end

    if (cmd.prod) begin
      prod_nxt = diff * $signed({1'b0, s_r});
    end

    if (cmd.emit) begin
      if (cmd.emit_comp) begin
        cur_nxt[el] = pos;
      end
      out_valid_nxt = 1'b1;
      out_idx_nxt   = cmd.idx;
      out_pos_nxt   = pos;
      out_fin_nxt   = !moving;
      out_last_nxt  = (el == LAST_IDX);
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIMS; i++) begin
        cur_r[i]    <= '0;
        start_r[i]  <= '0;
        goal_r[i]   <= '0;
        staged_r[i] <= '0;
      end
      acc_r       <= '0;
      dur_r       <= DUR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < DIMS; i++) begin
        cur_r[i]    <= cur_nxt[i];
        start_r[i]  <= start_nxt[i];
        goal_r[i]   <= goal_nxt[i];
        staged_r[i] <= staged_nxt[i];
      end
      acc_r       <= acc_nxt;
      dur_r       <= dur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    t2_r       <= t2_nxt;
    s_r        <= s_nxt;
    prod_r     <= prod_nxt;
    out_idx_r  <= out_idx_nxt;
    out_pos_r  <= out_pos_nxt;
    out_fin_r  <= out_fin_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.need_ease = moving && !snap;
  assign sts.out_valid = out_valid_r;
  assign sts.out_taken = out_valid_r && out_ready;

  assign out_valid = out_valid_r;
  assign out_index = out_idx_r;
  assign position  = out_pos_r;
  assign finished  = out_fin_r;
  assign last_out  = out_last_r;

endmodule

`default_nettype wire

// ===== design/svi_ctrl.sv =====
// ----------------------------------------------------------------------------
// svi_ctrl
// Controller: sequences divider, easing multiplies and per-element output.
// ----------------------------------------------------------------------------
`default_nettype none

module svi_ctrl #(
  parameter int DIMS = svi_pkg::DIMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_ready,
  output svi_pkg::ctrl_cmd_t cmd,
  input  svi_pkg::dp_sts_t   sts
);
  import svi_pkg::*;

  localparam int IDX_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIMS - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_SQR  = 7'b0000100,
    ST_EASE = 7'b0001000,
    ST_PROD = 7'b0010000,
    ST_EMIT = 7'b0100000,
    ST_HOLD = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              comp_r, comp_nxt;
  logic              take;

  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    comp_nxt      = comp_r;
    cmd           = '0;
    cmd.take      = take;
    cmd.idx       = 3'(cnt_r);
    cmd.emit_comp = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_cmd == CMD_TICK) begin
          cnt_nxt  = '0;
          step_nxt = '0;
          comp_nxt = sts.need_ease;
          state_nxt = sts.need_ease ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = ST_EASE;
      end
      ST_EASE: begin
        cmd.ease  = 1'b1;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (sts.out_taken) begin
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = comp_r ? ST_PROD : ST_EMIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      step_r  <= '0;
      comp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
    end
  end

  // the result register must be empty before a new element is loaded
  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_valid)
    else $error("emit while result register still full");

  // divider runs exactly one step per quotient bit
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DIV) |-> ##(DIV_STEPS) (state_r == ST_SQR))
    else $error("divider step count wrong");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> cnt_r <= LAST_IDX)
    else $error("element counter out of range");

  // a tick returns to idle only after its final element went out
  a_no_early_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && sts.out_taken && cnt_r != LAST_IDX) |=> state_r != ST_IDLE)
    else $error("tick ended before last element");

endmodule

`default_nettype wire

// ===== design/smoothstep_vector_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// smoothstep_vector_interpolator_core
// Animates DIMS signed Q16.16 coordinates toward a target on a smoothstep curve.
//
// in_ch carries transactions: tick (elapsed ms), retarget element or jump
// element; the element marked last commits the staged target vector.
// out_ch returns DIMS position transactions per tick, index 0 first, the
// final one flagged by last_out. cfg_we/cfg_wdata write duration_ms.
// Load and unused commands produce nothing on out_ch.
// A tick with motion in progress runs the bit-per-cycle restoring
// divider for time/duration, two easing multiplies, then per element a
// multiply, an update and an output step. A tick with no motion, or one
// that reaches the duration, skips the divider and the multiplies and
// goes straight to the per-element output.
// in_ch.ready is high only while no tick is in progress. When out_ch
// stalls the held position transaction stays stable and the sequencer waits.
// Reset clears all coordinate stores and elapsed time and sets the
// duration to 500 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothstep_vector_interpolator_core #(
  parameter int DIMS = svi_pkg::DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  svi_in_if.sink      in_ch,
  svi_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import svi_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  svi_ctrl #(
    .DIMS (DIMS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  svi_dp #(
    .DIMS (DIMS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_ch.cmd),
    .in_elapsed_ms   (in_ch.elapsed_ms),
    .in_elem_index   (in_ch.elem_index),
    .in_target_value (in_ch.target_value),
    .in_last_elem    (in_ch.last_elem),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_index       (out_ch.out_index),
    .position        (out_ch.position),
    .finished        (out_ch.finished),
    .last_out        (out_ch.last_out)
  );

endmodule

`default_nettype wire
